@@ sv/point_cluster_detector_unit_assert.svh @@
// Assertion macros for the point cluster detector checker.
// Clock and reset are taken from the scope of the module that expands them.
`ifndef POINT_CLUSTER_DETECTOR_UNIT_ASSERT_SVH
`define POINT_CLUSTER_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PCD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PCD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/pcd_pkg.sv @@
// Shared types, constants and command codes of the point cluster detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcd_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_W        = 16;
  localparam int HIST_W         = 16;
  localparam int LINK_W         = 12;
  localparam int LINK_RESET     = 100;

  // Cluster test constants
  localparam int SX_LIM_K   = 100;
  localparam int SY_MEAN_K  = 900;
  localparam int SY_DEV_K   = 200;
  localparam int SX2_LIM_K  = 50000;
  localparam int VAR_K      = 2000;
  localparam int HIST_MIN   = 200;
  localparam int XWIN_LO    = 400;
  localparam int XWIN_HI    = 600;
  localparam int YWIN_LO    = 3200;
  localparam int YWIN_HI    = 3600;
  localparam int XWIN_MIN   = 25;
  localparam int YWIN_MIN   = 10;

  typedef logic [LINK_W-1:0] link_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [HIST_W-1:0]         history_count;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic detected;
  } result_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SEED_PROBE,
    CMD_SEED_NEXT,
    CMD_REF_READ,
    CMD_REF_LATCH,
    CMD_SCAN,
    CMD_FR_NEXT,
    CMD_LAYER,
    CMD_EVAL0,
    CMD_EVAL1,
    CMD_EVAL2,
    CMD_EVAL3,
    CMD_EVAL4,
    CMD_CLEAR
  } dp_cmd_t;

  typedef struct packed {
    logic seed_found;
    logic s_last;
    logic k_last;
    logic j_last;
    logic nxt_empty;
    logic hit;
  } dp_status_t;

endpackage

`default_nettype wire

@@ sv/pcd_stream_if.sv @@
// Valid/ready channel carrying one payload of a given type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pcd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ sv/pcd_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pcd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/pcd_ctrl.sv @@
// Sequencer of the point cluster detector: loading, seed search, breadth-first
// scans, cluster tests and the result register. Depends on pcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               pt_valid,
  input  logic               pt_last,
  output logic               pt_ready,
  output logic               res_valid,
  input  logic               res_ready,
  output logic               res_detected,
  output pcd_pkg::dp_cmd_t   cmd,
  input  pcd_pkg::dp_status_t status
);
  import pcd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SEED, S_SEED_W1, S_SEED_W2, S_FR, S_REF, S_REF_L, S_SCAN,
    S_DR1, S_DR2, S_LAYER, S_EV0, S_EV1, S_EV2, S_EV3, S_EV4, S_DONE
  } state_t;

  state_t state, state_next;
  logic   res_load;

  assign pt_ready = (state == S_IDLE);
  assign res_load = (state == S_DONE) && (!res_valid || res_ready);

  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (pt_valid) begin
          cmd = CMD_LOAD;
          if (pt_last) state_next = S_SEED;
        end
      end
      S_SEED: begin
        cmd        = CMD_SEED_PROBE;
        state_next = S_SEED_W1;
      end
      S_SEED_W1: state_next = S_SEED_W2;
      S_SEED_W2: begin
        if (status.seed_found) begin
          state_next = S_FR;
        end else if (status.s_last) begin
          state_next = S_DONE;
        end else begin
          cmd        = CMD_SEED_NEXT;
          state_next = S_SEED;
        end
      end
      S_FR: state_next = S_REF;
      S_REF: begin
        cmd        = CMD_REF_READ;
        state_next = S_REF_L;
      end
      S_REF_L: begin
        cmd        = CMD_REF_LATCH;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (status.k_last) state_next = S_DR1;
      end
      // let the last scan transaction finish its label write
      S_DR1: state_next = S_DR2;
      S_DR2: begin
        if (status.j_last) begin
          state_next = S_LAYER;
        end else begin
          cmd        = CMD_FR_NEXT;
          state_next = S_FR;
        end
      end
      S_LAYER: begin
        if (status.nxt_empty) begin
          state_next = S_EV0;
        end else begin
          cmd        = CMD_LAYER;
          state_next = S_FR;
        end
      end
      S_EV0: begin
        cmd        = CMD_EVAL0;
        state_next = S_EV1;
      end
      S_EV1: begin
        cmd        = CMD_EVAL1;
        state_next = S_EV2;
      end
      S_EV2: begin
        cmd        = CMD_EVAL2;
        state_next = S_EV3;
      end
      S_EV3: begin
        cmd        = CMD_EVAL3;
        state_next = S_EV4;
      end
      S_EV4: begin
        cmd = CMD_EVAL4;
        if (status.s_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SEED;
        end
      end
      S_DONE: begin
        if (res_load) begin
          cmd        = CMD_CLEAR;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // EV4 advances the seed pointer on its own exit path
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
    if (res_load) res_detected <= status.hit;
  end

endmodule

`default_nettype wire

@@ sv/pcd_datapath.sv @@
// Datapath of the point cluster detector: point, label and frontier memories,
// the distance pipeline, cluster accumulators and the test unit.
// Depends on pcd_pkg and pcd_ram.
`timescale 1ns / 1ps
`default_nettype none

module pcd_datapath #(
  parameter int MAX_POINTS = pcd_pkg::MAX_POINTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  pcd_pkg::dp_cmd_t    cmd,
  input  pcd_pkg::point_t     pt,
  input  pcd_pkg::link_t      cfg_data,
  input  logic                cfg_we,
  output pcd_pkg::dp_status_t status
);
  import pcd_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int DX_W  = COORD_W + 1;
  localparam int D2_W  = 2 * COORD_W;
  localparam int SQ1_W = 2 * COORD_W - 1;
  localparam int SX_W  = COORD_W + CNT_W;
  localparam int SQ_W  = SQ1_W + CNT_W;
  localparam int DY_W  = SX_W + 2;
  localparam int T_W   = CNT_W + 16;
  localparam int CW    = SQ_W + 16;
  localparam int LO_W  = (SQ_W + 1) / 2;
  localparam int HI_W  = SQ_W - LO_W;
  localparam int VW    = 2 * CNT_W + 2 * COORD_W;

  typedef enum logic [1:0] {ST_NONE, ST_SEED, ST_LINK} stage_op_t;

  // configuration
  link_t             link_distance;
  logic [2*LINK_W-1:0] lim;

  // set and traversal counters
  logic [CNT_W-1:0]  point_count, s, k, j, ncur, nnext, cur_label;
  logic [HIST_W-1:0] hist;
  logic              sel;
  logic              load_en;

  // memory ports
  logic [IDX_W-1:0]          xy_raddr, lbl_raddr, lbl_waddr, fr_waddr;
  logic signed [COORD_W-1:0] x_rd, y_rd;
  logic [CNT_W-1:0]          lbl_rd, lbl_wdata;
  logic                      lbl_we, fa_we, fb_we;
  logic [IDX_W-1:0]          fa_rd, fb_rd, cur_rd;

  // distance pipeline
  logic signed [COORD_W-1:0] ref_x, ref_y;
  stage_op_t                 op1, op2;
  logic [IDX_W-1:0]          idx1, idx2;
  logic signed [DX_W-1:0]    dx, dy, ax;
  logic signed [2*DX_W-1:0]  dxx_p, dyy_p;
  logic signed [D2_W-1:0]    xsq_p, ysq_p;
  logic [D2_W-1:0]           dxx2, dyy2;
  logic [SQ1_W-1:0]          xsq2, ysq2;
  logic signed [COORD_W-1:0] x2, y2;
  logic                      lz2, xw2, yw2;
  logic [D2_W:0]             dist_sq;
  logic                      seed_act, link_act;

  // cluster accumulators
  logic [CNT_W-1:0]       acc_n, acc_nxw, acc_nyw;
  logic signed [SX_W-1:0] acc_sx, acc_sy;
  logic [SQ_W-1:0]        acc_sx2, acc_sy2;

  // test unit
  logic [SX_W-1:0]          abs_sx;
  logic signed [DY_W-1:0]   dy_dev, sy_mean;
  logic [DY_W-1:0]          abs_dy;
  logic [T_W-1:0]           t100, t200, t50k;
  logic [2*CNT_W-1:0]       nn;
  logic signed [2*SX_W-1:0] sysq_p;
  logic [2*SX_W-1:0]        sysq;
  logic [CNT_W+LO_W-1:0]    plo;
  logic [CNT_W+HI_W-1:0]    phi;
  logic [VW-1:0]            n2k, rhs, lhs;
  logic                     c_sx, c_dy, c_sx2, c_win, hit;

  assign load_en = (cmd == CMD_LOAD) && (point_count < CNT_W'(MAX_POINTS));

  always_comb begin
    unique case (cmd)
      CMD_REF_READ:   xy_raddr = cur_rd;
      CMD_SEED_PROBE: xy_raddr = s[IDX_W-1:0];
      default:        xy_raddr = k[IDX_W-1:0];
    endcase
  end
  assign lbl_raddr = (cmd == CMD_SEED_PROBE) ? s[IDX_W-1:0] : k[IDX_W-1:0];

  pcd_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_x_ram (
    .clk(clk), .we(load_en), .waddr(point_count[IDX_W-1:0]), .wdata(pt.point_x),
    .raddr(xy_raddr), .rdata(x_rd)
  );

  pcd_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_y_ram (
    .clk(clk), .we(load_en), .waddr(point_count[IDX_W-1:0]), .wdata(pt.point_y),
    .raddr(xy_raddr), .rdata(y_rd)
  );

  // labels are zeroed as each point is loaded, so no clearing pass is needed
  assign lbl_we    = load_en || seed_act || link_act;
  assign lbl_waddr = load_en ? point_count[IDX_W-1:0] : idx2;
  assign lbl_wdata = load_en ? '0 : (seed_act ? cur_label + 1'b1 : cur_label);

  pcd_ram #(.WIDTH(CNT_W), .DEPTH(MAX_POINTS)) u_lbl_ram (
    .clk(clk), .we(lbl_we), .waddr(lbl_waddr), .wdata(lbl_wdata),
    .raddr(lbl_raddr), .rdata(lbl_rd)
  );

  // ping-pong frontier: sel=0 means A holds the current layer
  assign fr_waddr = seed_act ? '0 : nnext[IDX_W-1:0];
  assign fa_we    = (seed_act && !sel) || (link_act && sel);
  assign fb_we    = (seed_act && sel) || (link_act && !sel);
  assign cur_rd   = sel ? fb_rd : fa_rd;

  pcd_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_fa_ram (
    .clk(clk), .we(fa_we), .waddr(fr_waddr), .wdata(idx2),
    .raddr(j[IDX_W-1:0]), .rdata(fa_rd)
  );

  pcd_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_fb_ram (
    .clk(clk), .we(fb_we), .waddr(fr_waddr), .wdata(idx2),
    .raddr(j[IDX_W-1:0]), .rdata(fb_rd)
  );

  // stage 1: memory data in, squares out
  assign dx    = DX_W'(x_rd) - DX_W'(ref_x);
  assign dy    = DX_W'(y_rd) - DX_W'(ref_y);
  assign dxx_p = dx * dx;
  assign dyy_p = dy * dy;
  assign xsq_p = x_rd * x_rd;
  assign ysq_p = y_rd * y_rd;
  assign ax    = x_rd[COORD_W-1] ? -DX_W'(x_rd) : DX_W'(x_rd);

  // stage 2: link decision and accumulation
  assign dist_sq  = {1'b0, dxx2} + {1'b0, dyy2};
  assign seed_act = (op2 == ST_SEED) && lz2;
  assign link_act = (op2 == ST_LINK) && lz2 && (dist_sq < (D2_W + 1)'(lim));

  always_ff @(posedge clk) begin
    if (rst) begin
      op1 <= ST_NONE;
      op2 <= ST_NONE;
    end else begin
      unique case (cmd)
        CMD_SEED_PROBE: op1 <= ST_SEED;
        CMD_SCAN:       op1 <= ST_LINK;
        default:        op1 <= ST_NONE;
      endcase
      op2 <= op1;
    end
    idx1 <= xy_raddr;
    idx2 <= idx1;
    lz2  <= (lbl_rd == '0);
    dxx2 <= dxx_p[D2_W-1:0];
    dyy2 <= dyy_p[D2_W-1:0];
    xsq2 <= xsq_p[SQ1_W-1:0];
    ysq2 <= ysq_p[SQ1_W-1:0];
    x2   <= x_rd;
    y2   <= y_rd;
    xw2  <= (ax > XWIN_LO) && (ax < XWIN_HI);
    yw2  <= (y_rd > YWIN_LO) && (y_rd < YWIN_HI);
    if (cmd == CMD_REF_LATCH) begin
      ref_x <= x_rd;
      ref_y <= y_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (seed_act) begin
      acc_n   <= CNT_W'(1);
      acc_sx  <= SX_W'(x2);
      acc_sy  <= SX_W'(y2);
      acc_sx2 <= SQ_W'(xsq2);
      acc_sy2 <= SQ_W'(ysq2);
      acc_nxw <= CNT_W'(xw2);
      acc_nyw <= CNT_W'(yw2);
    end else if (link_act) begin
      acc_n   <= acc_n + 1'b1;
      acc_sx  <= acc_sx + SX_W'(x2);
      acc_sy  <= acc_sy + SX_W'(y2);
      acc_sx2 <= acc_sx2 + SQ_W'(xsq2);
      acc_sy2 <= acc_sy2 + SQ_W'(ysq2);
      acc_nxw <= acc_nxw + CNT_W'(xw2);
      acc_nyw <= acc_nyw + CNT_W'(yw2);
    end
  end

  // counters and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      link_distance <= LINK_W'(LINK_RESET);
      lim           <= (2 * LINK_W)'(LINK_RESET * LINK_RESET);
      point_count   <= '0;
      hit           <= 1'b0;
      sel           <= 1'b0;
    end else begin
      if (cfg_we) link_distance <= cfg_data;
      lim <= link_distance * link_distance;
      if (load_en) point_count <= point_count + 1'b1;
      if (cmd == CMD_CLEAR) point_count <= '0;
      if (cmd == CMD_LOAD && pt.last_point) begin
        hist      <= pt.history_count;
        s         <= '0;
        cur_label <= '0;
        hit       <= 1'b0;
      end
      if (cmd == CMD_SEED_NEXT || (cmd == CMD_EVAL4 && !status.s_last)) s <= s + 1'b1;
      if (cmd == CMD_REF_LATCH) k <= '0;
      if (cmd == CMD_SCAN) k <= k + 1'b1;
      if (cmd == CMD_FR_NEXT) j <= j + 1'b1;
      if (cmd == CMD_LAYER) begin
        ncur  <= nnext;
        nnext <= '0;
        sel   <= ~sel;
        j     <= '0;
      end
      if (seed_act) begin
        cur_label <= cur_label + 1'b1;
        ncur      <= CNT_W'(1);
        nnext     <= '0;
        j         <= '0;
      end
      if (link_act) nnext <= nnext + 1'b1;
      if (cmd == CMD_EVAL4) hit <= hit || (c_sx && c_dy && c_sx2 && (lhs > rhs)) || c_win;
    end
  end

  // cluster tests, one step per command
  assign sy_mean = DY_W'(acc_sy) - $signed(DY_W'(acc_n) * DY_W'(SY_MEAN_K));
  assign abs_dy  = dy_dev[DY_W-1] ? DY_W'(-dy_dev) : DY_W'(dy_dev);
  assign sysq_p  = acc_sy * acc_sy;

  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_EVAL0: begin
        abs_sx <= acc_sx[SX_W-1] ? SX_W'(-acc_sx) : SX_W'(acc_sx);
        dy_dev <= sy_mean;
        t100   <= T_W'(acc_n) * T_W'(SX_LIM_K);
        t200   <= T_W'(acc_n) * T_W'(SY_DEV_K);
        t50k   <= T_W'(acc_n) * T_W'(SX2_LIM_K);
        nn     <= (2 * CNT_W)'(acc_n) * (2 * CNT_W)'(acc_n);
        sysq   <= sysq_p;
      end
      CMD_EVAL1: begin
        c_sx  <= CW'(abs_sx) < CW'(t100);
        c_dy  <= CW'(abs_dy) < CW'(t200);
        c_sx2 <= CW'(acc_sx2) < CW'(t50k);
        c_win <= (hist > HIST_MIN) && (int'(acc_nxw) > XWIN_MIN)
                 && (int'(acc_nyw) > YWIN_MIN);
        plo   <= (CNT_W + LO_W)'(acc_n) * (CNT_W + LO_W)'(acc_sy2[LO_W-1:0]);
        n2k   <= VW'(nn) * VW'(VAR_K);
      end
      CMD_EVAL2: begin
        phi <= (CNT_W + HI_W)'(acc_n) * (CNT_W + HI_W)'(acc_sy2[SQ_W-1:LO_W]);
        rhs <= VW'(sysq) + n2k;
      end
      CMD_EVAL3: begin
        lhs <= (VW'(phi) << LO_W) + VW'(plo);
      end
      default: begin
      end
    endcase
  end

  assign status.seed_found = seed_act;
  assign status.s_last     = (s == point_count - 1'b1);
  assign status.k_last     = (k == point_count - 1'b1);
  assign status.j_last     = (j == ncur - 1'b1);
  assign status.nxt_empty  = (nnext == '0);
  assign status.hit        = hit;

endmodule

`default_nettype wire

@@ sv/point_cluster_detector_unit.sv @@
// Top level of the point cluster detector: sequencer plus datapath.
// Depends on pcd_pkg, pcd_stream_if, pcd_ctrl and pcd_datapath.
//
// Usage:
//   points  - one transaction per 2-D point; the point flagged last_point
//             closes the set and starts clustering. Points past MAX_POINTS
//             are dropped, the last flag still takes effect.
//   results - one transaction per set, detected = 1 when a cluster passes
//             the mean/variance test or the window test.
//   cfg     - link distance write, always ready; write only while idle.
// Processing: a non-final point leaves the block idle and ready for the next
//   point. After the last point the block probes the points for seeds; each
//   seed starts breadth-first scans (one distance check per cycle through the
//   point memory port), followed by the cluster tests.
// The result sits in an output register; points of the next set are taken
//   while it waits. A set that ends while the result is still unread holds
//   in its final state until the receiver takes the older one.
// Reset returns the link distance to 100 and empties the point store; no
//   clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module point_cluster_detector_unit #(
  parameter int MAX_POINTS = pcd_pkg::MAX_POINTS_DEF
) (
  input logic          clk,
  input logic          rst,
  pcd_stream_if.sink   points,
  pcd_stream_if.source results,
  pcd_stream_if.sink   cfg
);
  import pcd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       res_detected;

  assign cfg.ready                = 1'b1;
  assign results.payload.detected = res_detected;

  pcd_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .pt_valid     (points.valid),
    .pt_last      (points.payload.last_point),
    .pt_ready     (points.ready),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .res_detected (res_detected),
    .cmd          (cmd),
    .status       (status)
  );

  pcd_datapath #(.MAX_POINTS(MAX_POINTS)) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .pt       (points.payload),
    .cfg_data (cfg.payload),
    .cfg_we   (cfg.valid),
    .status   (status)
  );

endmodule

`default_nettype wire

@@ sv/pcd_checker.sv @@
// Port-level checker for the point cluster detector and its bind.
// Depends on point_cluster_detector_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "point_cluster_detector_unit_assert.svh"

module pcd_checker (
  input logic clk,
  input logic rst,
  input logic pts_valid,
  input logic pts_ready,
  input logic pts_last,
  input logic res_valid,
  input logic res_ready,
  input logic res_detected
);

  `PCD_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")
  `PCD_ASSERT_NXT(a_res_stable, res_valid && !res_ready, $stable(res_detected), "result changed while stalled")
  `PCD_ASSERT_NXT(a_busy_after_last, pts_valid && pts_ready && pts_last, !pts_ready, "point taken during clustering")
  `PCD_ASSERT_IMP(a_res_from_busy, $rose(res_valid), $past(!pts_ready), "result raised while loading")

endmodule

bind point_cluster_detector_unit pcd_checker u_pcd_checker (
  .clk          (clk),
  .rst          (rst),
  .pts_valid    (points.valid),
  .pts_ready    (points.ready),
  .pts_last     (points.payload.last_point),
  .res_valid    (results.valid),
  .res_ready    (results.ready),
  .res_detected (results.payload.detected)
);

`default_nettype wire
